// File: rtl/core/pid_clamped_terms_core_macros.svh
// assertion macros for the pid core
`ifndef PID_CLAMPED_TERMS_CORE_MACROS_SVH
`define PID_CLAMPED_TERMS_CORE_MACROS_SVH

`ifndef SYNTH
`define PCT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pid core check failed");
`define PCT_ASSERT_NEVER(label, expr) \
  `PCT_ASSERT(label, !(expr))
`else
`define PCT_ASSERT(label, prop)
`define PCT_ASSERT_NEVER(label, expr)
`endif

`endif

// File: rtl/core/pct_pkg.sv
package pct_pkg;

  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 23;
  localparam int ISUM_LIM_W = 24;
  localparam int ISUM_W     = 25;
  localparam int TERM_W     = 24;
  localparam int DRIVE_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CLAMP_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN     = 3'd0,
    REG_I_GAIN     = 3'd1,
    REG_D_GAIN     = 3'd2,
    REG_P_LIMIT    = 3'd3,
    REG_I_LIMIT    = 3'd4,
    REG_D_LIMIT    = 3'd5,
    REG_OUT_LIMIT  = 3'd6,
    REG_ISUM_LIMIT = 3'd7
  } pct_reg_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]         p_lim;
    logic [LIM_W-1:0]         i_lim;
    logic [LIM_W-1:0]         d_lim;
    logic [LIM_W-1:0]         out_lim;
    logic [ISUM_LIM_W-1:0]    isum_lim;
  } pct_cfg_t;

  typedef struct packed {
    logic load_in;
    logic load_front;
    logic load_prod;
    logic load_term;
    logic load_out;
  } pct_ctl_t;

  // symmetric saturation, result always fits ISUM_W bits
  function automatic logic signed [ISUM_W-1:0] clamp_sym(
    input logic signed [CLAMP_W-1:0] v,
    input logic [ISUM_LIM_W-1:0]     lim
  );
    logic signed [CLAMP_W-1:0] hi;
    logic signed [CLAMP_W-1:0] lo;
    hi = $signed({{(CLAMP_W-ISUM_LIM_W){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      return hi[ISUM_W-1:0];
    end else if (v < lo) begin
      return lo[ISUM_W-1:0];
    end
    return v[ISUM_W-1:0];
  endfunction

endpackage

// File: rtl/core/pct_ifs.sv
interface pct_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] target;
  logic signed [SAMPLE_WIDTH-1:0] feedback;
  logic                           limit_enable;
  logic [22:0]                    limit_value;

  modport source (output valid, output target, output feedback, output limit_enable,
                  output limit_value, input ready);
  modport sink (input valid, input target, input feedback, input limit_enable,
                input limit_value, output ready);
endinterface

interface pct_drive_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

// File: rtl/core/pid_clamped_terms_core.sv
// Positional PID step with clamped terms and anti-windup. Each sample
// transaction gives error = target - feedback; the integral sum is clamped to
// +/- integral_sum_limit, the P, I and D terms use signed Q8.8 gains, are
// shifted down by GAIN_FRAC_BITS and clamped to their own limits, and their
// sum clamped to the active output limit is the drive. A transaction with
// limit_enable set makes limit_value the output limit for itself and all
// later ones until reset or the next such transaction. One transaction is
// accepted per cycle while the output is not stalled; each passes through the
// five register stages (input, error and integral update, multipliers, term
// clamps, drive), the first of which loads at the accepting edge. Only reset
// clears the integral sum and the previous error.
`include "pid_clamped_terms_core_macros.svh"

module pid_clamped_terms_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  pct_sample_if.sink                      sample,
  pct_drive_if.source                     result,
  input  logic                            cfg_wr_en,
  input  logic [pct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import pct_pkg::*;

  pct_cfg_t cfg;
  pct_ctl_t ctl;

  logic v1, v2, v3, v4, v5;
  logic ready1, ready2, ready3, ready4, ready5;

  logic signed [SAMPLE_WIDTH:0]   err;
  logic signed [SAMPLE_WIDTH+1:0] derr;
  logic signed [ISUM_W-1:0]       isum;
  logic [LIM_W-1:0]               lim;

  logic signed [TERM_W-1:0]       p_term;
  logic signed [TERM_W-1:0]       i_term;
  logic signed [TERM_W-1:0]       d_term;
  logic [LIM_W-1:0]               term_lim;

  logic signed [TERM_W+1:0]       sum;
  logic signed [ISUM_W-1:0]       sum_clamp;
  logic signed [DRIVE_W-1:0]      drive_q;

  // each stage takes a new transaction when empty or when it moves on
  always_comb begin
    ready5 = !v5 || result.ready;
    ready4 = !v4 || ready5;
    ready3 = !v3 || ready4;
    ready2 = !v2 || ready3;
    ready1 = !v1 || ready2;
    ctl.load_in    = sample.valid && ready1;
    ctl.load_front = v1 && ready2;
    ctl.load_prod  = v2 && ready3;
    ctl.load_term  = v3 && ready4;
    ctl.load_out   = v4 && ready5;
  end

  assign sample.ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= sample.valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        v4 <= v3;
      end
      if (ready5) begin
        v5 <= v4;
      end
    end
  end

  pct_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  pct_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cfg          (cfg),
    .target       (sample.target),
    .feedback     (sample.feedback),
    .limit_enable (sample.limit_enable),
    .limit_value  (sample.limit_value),
    .err          (err),
    .derr         (derr),
    .isum         (isum),
    .lim          (lim)
  );

  pct_terms #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_terms (
    .clk      (clk),
    .ctl      (ctl),
    .cfg      (cfg),
    .err      (err),
    .derr     (derr),
    .isum     (isum),
    .lim      (lim),
    .p_term   (p_term),
    .i_term   (i_term),
    .d_term   (d_term),
    .term_lim (term_lim)
  );

  always_comb begin
    sum       = (TERM_W+2)'(p_term) + (TERM_W+2)'(i_term) + (TERM_W+2)'(d_term);
    sum_clamp = clamp_sym(CLAMP_W'(sum), {1'b0, term_lim});
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      drive_q <= sum_clamp[DRIVE_W-1:0];
    end
  end

  assign result.valid = v5;
  assign result.drive = drive_q;

  // a waiting result is never overwritten
  `PCT_ASSERT_NEVER(a_no_overwrite, v5 && !result.ready && ctl.load_out)
  // input stalls only when every stage holds a transaction
  `PCT_ASSERT(a_stall_full, !sample.ready |-> (v1 && v2 && v3 && v4 && v5))
  // the clamp never yields the most negative code
  `PCT_ASSERT(a_drive_sym, result.valid |-> (result.drive != {1'b1, {(DRIVE_W-1){1'b0}}}))

endmodule

// File: rtl/core/pct_cfg_regs.sv
module pct_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [pct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  output pct_pkg::pct_cfg_t                 cfg
);
  import pct_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      unique case (pct_reg_e'(cfg_index))
        REG_P_GAIN:     cfg.kp       <= $signed(cfg_wr_data[GAIN_W-1:0]);
        REG_I_GAIN:     cfg.ki       <= $signed(cfg_wr_data[GAIN_W-1:0]);
        REG_D_GAIN:     cfg.kd       <= $signed(cfg_wr_data[GAIN_W-1:0]);
        REG_P_LIMIT:    cfg.p_lim    <= cfg_wr_data[LIM_W-1:0];
        REG_I_LIMIT:    cfg.i_lim    <= cfg_wr_data[LIM_W-1:0];
        REG_D_LIMIT:    cfg.d_lim    <= cfg_wr_data[LIM_W-1:0];
        REG_OUT_LIMIT:  cfg.out_lim  <= cfg_wr_data[LIM_W-1:0];
        REG_ISUM_LIMIT: cfg.isum_lim <= cfg_wr_data[ISUM_LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/pct_front.sv
module pct_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pct_pkg::pct_ctl_t                ctl,
  input  pct_pkg::pct_cfg_t                cfg,
  input  logic signed [SAMPLE_WIDTH-1:0]   target,
  input  logic signed [SAMPLE_WIDTH-1:0]   feedback,
  input  logic                             limit_enable,
  input  logic [pct_pkg::LIM_W-1:0]        limit_value,
  output logic signed [SAMPLE_WIDTH:0]     err,
  output logic signed [SAMPLE_WIDTH+1:0]   derr,
  output logic signed [pct_pkg::ISUM_W-1:0] isum,
  output logic [pct_pkg::LIM_W-1:0]        lim
);
  import pct_pkg::*;

  localparam int ERR_W = SAMPLE_WIDTH + 1;
  localparam int DERR_W = SAMPLE_WIDTH + 2;
  localparam int RAW_W = ((ISUM_W > ERR_W) ? ISUM_W : ERR_W) + 1;

  logic signed [SAMPLE_WIDTH-1:0] target_q;
  logic signed [SAMPLE_WIDTH-1:0] feedback_q;
  logic                           limit_enable_q;
  logic [LIM_W-1:0]               limit_value_q;

  logic [LIM_W-1:0]               held_limit;
  logic                           limit_held;

  logic signed [ERR_W-1:0]        err_next;
  logic signed [DERR_W-1:0]       derr_next;
  logic signed [RAW_W-1:0]        isum_raw;
  logic signed [ISUM_W-1:0]       isum_next;
  logic [LIM_W-1:0]               lim_next;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      target_q       <= target;
      feedback_q     <= feedback;
      limit_enable_q <= limit_enable;
      limit_value_q  <= limit_value;
    end
  end

  always_comb begin
    err_next  = ERR_W'(target_q) - ERR_W'(feedback_q);
    // err holds the previous error until the next transaction enters
    derr_next = DERR_W'(err_next) - DERR_W'(err);
    isum_raw  = RAW_W'(isum) + RAW_W'(err_next);
    isum_next = clamp_sym(CLAMP_W'(isum_raw), cfg.isum_lim);
    priority if (limit_enable_q) begin
      lim_next = limit_value_q;
    end else if (limit_held) begin
      lim_next = held_limit;
    end else begin
      lim_next = cfg.out_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err        <= '0;
      isum       <= '0;
      held_limit <= '0;
      limit_held <= 1'b0;
    end else if (ctl.load_front) begin
      err  <= err_next;
      isum <= isum_next;
      if (limit_enable_q) begin
        held_limit <= limit_value_q;
        limit_held <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_front) begin
      derr <= derr_next;
      lim  <= lim_next;
    end
  end

endmodule

// File: rtl/core/pct_terms.sv
module pct_terms #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  pct_pkg::pct_ctl_t                 ctl,
  input  pct_pkg::pct_cfg_t                 cfg,
  input  logic signed [SAMPLE_WIDTH:0]      err,
  input  logic signed [SAMPLE_WIDTH+1:0]    derr,
  input  logic signed [pct_pkg::ISUM_W-1:0] isum,
  input  logic [pct_pkg::LIM_W-1:0]         lim,
  output logic signed [pct_pkg::TERM_W-1:0] p_term,
  output logic signed [pct_pkg::TERM_W-1:0] i_term,
  output logic signed [pct_pkg::TERM_W-1:0] d_term,
  output logic [pct_pkg::LIM_W-1:0]         term_lim
);
  import pct_pkg::*;

  localparam int PP_W = SAMPLE_WIDTH + 1 + GAIN_W;
  localparam int PI_W = ISUM_W + GAIN_W;
  localparam int PD_W = SAMPLE_WIDTH + 2 + GAIN_W;

  logic signed [PP_W-1:0]   prod_p;
  logic signed [PI_W-1:0]   prod_i;
  logic signed [PD_W-1:0]   prod_d;
  logic [LIM_W-1:0]         prod_lim;

  logic signed [ISUM_W-1:0] p_clamp;
  logic signed [ISUM_W-1:0] i_clamp;
  logic signed [ISUM_W-1:0] d_clamp;

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_p   <= PP_W'(err) * PP_W'(cfg.kp);
      prod_i   <= PI_W'(isum) * PI_W'(cfg.ki);
      prod_d   <= PD_W'(derr) * PD_W'(cfg.kd);
      prod_lim <= lim;
    end
  end

  // arithmetic shift drops the gain fraction, rounding toward minus infinity
  always_comb begin
    p_clamp = clamp_sym(CLAMP_W'(prod_p >>> GAIN_FRAC_BITS), {1'b0, cfg.p_lim});
    i_clamp = clamp_sym(CLAMP_W'(prod_i >>> GAIN_FRAC_BITS), {1'b0, cfg.i_lim});
    d_clamp = clamp_sym(CLAMP_W'(prod_d >>> GAIN_FRAC_BITS), {1'b0, cfg.d_lim});
  end

  always_ff @(posedge clk) begin
    if (ctl.load_term) begin
      p_term   <= p_clamp[TERM_W-1:0];
      i_term   <= i_clamp[TERM_W-1:0];
      d_term   <= d_clamp[TERM_W-1:0];
      term_lim <= prod_lim;
    end
  end

endmodule
